// ----- sv/hfpd_pkg.sv -----
package hfpd_pkg;

   localparam int GAIN_FRAC_BITS_DEF  = 8;
   localparam int GRADE_FRAC_BITS_DEF = 16;

   // field and datapath widths fixed by the interface
   localparam int POS_W      = 13;
   localparam int ERR_W      = 13;
   localparam int DIFF_W     = 14;
   localparam int MAG_W      = 12;
   localparam int GAIN_W     = 16;
   localparam int BASE_W     = 8;
   localparam int SPEED_W    = 9;
   localparam int SPAN_W     = 11;
   localparam int PD_W       = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam int SETPOINT    = 3500;
   localparam int POS_MAX     = 7000;
   localparam int SPEED_MAX   = 255;
   localparam int SPEED_MIN   = -180;
   localparam int SMALL_END   = 750;
   localparam int MED_START   = 500;
   localparam int MED_PEAK    = 1125;
   localparam int MED_END     = 1750;
   localparam int LARGE_START = 1500;
   localparam int LARGE_END   = 3500;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN,
      CSR_DERIV_GAIN,
      CSR_SMALL_WEIGHT,
      CSR_MEDIUM_WEIGHT,
      CSR_LARGE_WEIGHT,
      CSR_BASE_SPEED
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_ERR_KP,
      MUL_DIFF_KD,
      MUL_GRADE
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_PD_LOAD,
      ACC_PD_ADD,
      ACC_FZ_ADD,
      ACC_TOTAL,
      ACC_EFFORT
   } acc_op_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_INIT,
      DIV_STEP
   } div_op_type;

   typedef enum logic [1:0] {
      GRADE_SMALL,
      GRADE_MEDIUM,
      GRADE_LARGE
   } grade_sel_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_WAIT_REQ,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      logic                latch;
      logic                emit;
      mul_sel_type         mul_sel;
      acc_op_type          acc_op;
      div_op_type          div_op;
      grade_sel_type       grade_sel;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   function automatic ucode_type uc(input logic latch, input logic emit,
                                    input mul_sel_type mul_sel, input acc_op_type acc_op,
                                    input div_op_type div_op, input grade_sel_type grade_sel,
                                    input cond_type cond, input logic [STEP_W-1:0] target);
      ucode_type w;
      w.latch     = latch;
      w.emit      = emit;
      w.mul_sel   = mul_sel;
      w.acc_op    = acc_op;
      w.div_op    = div_op;
      w.grade_sel = grade_sel;
      w.cond      = cond;
      w.target    = target;
      return w;
   endfunction

   // control store: one word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = uc(1'b0, 1'b0, MUL_NONE, ACC_NONE, DIV_NONE, GRADE_SMALL, COND_NEXT, 4'd0);
      unique case (step)
         4'd0: begin
            w = uc(1'b1, 1'b0, MUL_NONE, ACC_NONE, DIV_NONE, GRADE_SMALL, COND_WAIT_REQ, 4'd0);
         end
         4'd1: begin
            w = uc(1'b0, 1'b0, MUL_ERR_KP, ACC_NONE, DIV_NONE, GRADE_SMALL, COND_NEXT, 4'd0);
         end
         4'd2: begin
            w = uc(1'b0, 1'b0, MUL_DIFF_KD, ACC_PD_LOAD, DIV_NONE, GRADE_SMALL, COND_NEXT, 4'd0);
         end
         4'd3: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_PD_ADD, DIV_INIT, GRADE_SMALL, COND_NEXT, 4'd0);
         end
         4'd4: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_NONE, DIV_STEP, GRADE_SMALL, COND_NEXT, 4'd0);
         end
         4'd5: begin
            w = uc(1'b0, 1'b0, MUL_GRADE, ACC_NONE, DIV_NONE, GRADE_SMALL, COND_NEXT, 4'd0);
         end
         4'd6: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_FZ_ADD, DIV_INIT, GRADE_MEDIUM, COND_NEXT, 4'd0);
         end
         4'd7: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_NONE, DIV_STEP, GRADE_MEDIUM, COND_NEXT, 4'd0);
         end
         4'd8: begin
            w = uc(1'b0, 1'b0, MUL_GRADE, ACC_NONE, DIV_NONE, GRADE_MEDIUM, COND_NEXT, 4'd0);
         end
         4'd9: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_FZ_ADD, DIV_INIT, GRADE_LARGE, COND_NEXT, 4'd0);
         end
         4'd10: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_NONE, DIV_STEP, GRADE_LARGE, COND_NEXT, 4'd0);
         end
         4'd11: begin
            w = uc(1'b0, 1'b0, MUL_GRADE, ACC_NONE, DIV_NONE, GRADE_LARGE, COND_NEXT, 4'd0);
         end
         4'd12: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_FZ_ADD, DIV_NONE, GRADE_LARGE, COND_NEXT, 4'd0);
         end
         4'd13: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_TOTAL, DIV_NONE, GRADE_LARGE, COND_NEXT, 4'd0);
         end
         4'd14: begin
            w = uc(1'b0, 1'b0, MUL_NONE, ACC_EFFORT, DIV_NONE, GRADE_LARGE, COND_NEXT, 4'd0);
         end
         4'd15: begin
            w = uc(1'b0, 1'b1, MUL_NONE, ACC_NONE, DIV_NONE, GRADE_LARGE, COND_WAIT_OUT, 4'd0);
         end
      endcase
      return w;
   endfunction

endpackage

// ----- sv/hybrid_fuzzy_pd_steering.sv -----
// Steering controller for a line follower. Each request carries a line position
// (0..7000, 3500 centred; larger values are treated as 7000). The block forms the error
// 3500 - position, a PD term from the Q8.8 gains, and a fuzzy term from three membership
// grades (small, medium, large) of the error magnitude weighted by Q8.8 output weights.
// The two terms are averaged and truncated toward zero to give the effort; the response
// carries left = base + effort and right = base - effort, each clamped to -180..255.
// The error of each request is kept for the derivative of the next one; reset clears it,
// the step, output valid and csr registers to zero. The user must write registers through
// the csr port only while no request is in flight; the block does not enforce this. One
// request is worked on at a time by a 16-step microprogram running one step per cycle,
// but it waits at its first step for a request and holds at its last step only while the
// previous response is still waiting. Each grade is the product of its numerator and a
// fixed reciprocal of the span, exact to the last bit, so no step waits on a divider. A
// finished response waits in the output register while the next request is taken.
module hybrid_fuzzy_pd_steering #(
   parameter int GAIN_FRAC_BITS  = hfpd_pkg::GAIN_FRAC_BITS_DEF,
   parameter int GRADE_FRAC_BITS = hfpd_pkg::GRADE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hfpd_pkg::REQ_DATA_W-1:0]   req_tdata,   // [12:0] line_position
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hfpd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [8:0] left_speed, [17:9] right_speed
   input  logic                              csr_we,
   input  logic [hfpd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [hfpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hfpd_pkg::*;

   localparam int GRADE_W = GRADE_FRAC_BITS + 1;
   localparam int OPA_W   = (GRADE_FRAC_BITS + 2 > DIFF_W) ? GRADE_FRAC_BITS + 2 : DIFF_W;
   localparam int OPB_W   = GAIN_W + 1;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int FZ_W    = GRADE_FRAC_BITS + GAIN_W + 3;
   localparam int TOT_W   = PD_W + GRADE_FRAC_BITS + 1;
   localparam int SHIFT   = GRADE_FRAC_BITS + GAIN_FRAC_BITS + 1;
   localparam int EFF_W   = TOT_W - SHIFT;
   localparam int SUM_W   = EFF_W + 2;
   localparam logic [TOT_W-1:0] TRUNC_BIAS = {{(TOT_W - SHIFT){1'b0}}, {SHIFT{1'b1}}};

   // reciprocals rounded up; with 22 extra bits the floor of numerator times reciprocal
   // matches the true quotient for every numerator the curves produce
   localparam int     RECIP_SHIFT = 22;
   localparam int     RECIP_W     = GRADE_FRAC_BITS + 13;
   localparam int     QPROD_W     = SPAN_W + RECIP_W;
   localparam longint RECIP_ONE   = longint'(1) << (GRADE_FRAC_BITS + RECIP_SHIFT);
   localparam logic [RECIP_W-1:0] RECIP_SMALL =
      RECIP_W'((RECIP_ONE + SMALL_END - 1) / SMALL_END);
   localparam logic [RECIP_W-1:0] RECIP_MEDIUM =
      RECIP_W'((RECIP_ONE + (MED_PEAK - MED_START) - 1) / (MED_PEAK - MED_START));
   localparam logic [RECIP_W-1:0] RECIP_LARGE =
      RECIP_W'((RECIP_ONE + (LARGE_END - LARGE_START) - 1) / (LARGE_END - LARGE_START));

   // control state
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic [GAIN_W-1:0]         prop_gain_ff, deriv_gain_ff;
   logic [GAIN_W-1:0]         small_weight_ff, medium_weight_ff, large_weight_ff;
   logic [BASE_W-1:0]         base_speed_ff;

   // datapath
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PD_W-1:0]    pd_ff, pd_in;
   logic [FZ_W-1:0]           fz_ff, fz_in;
   logic signed [TOT_W-1:0]   tot_ff, tot_in;
   logic signed [EFF_W-1:0]   eff_ff, eff_in;
   logic [SPAN_W-1:0]         num_ff, num_in;
   logic [RECIP_W-1:0]        recip_ff, recip_in;
   logic [GRADE_W-1:0]        quo_ff, quo_in;
   logic                      full_ff, full_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   ucode_type                 word;
   logic                      req_accept;
   logic                      out_free;
   logic [POS_W-1:0]          pos_c;
   logic signed [DIFF_W-1:0]  err_wide;
   logic signed [ERR_W-1:0]   err_new;
   logic signed [OPA_W-1:0]   opa;
   logic signed [OPB_W-1:0]   opb;
   logic [GAIN_W-1:0]         weight;
   logic [GRADE_W-1:0]        grade;
   logic [SPAN_W-1:0]         num;
   logic [RECIP_W-1:0]        recip_sel;
   logic [QPROD_W-1:0]        quo_prod;
   logic signed [TOT_W-1:0]   fz_signed;
   logic signed [TOT_W-1:0]   tot_biased;
   logic signed [SUM_W-1:0]   base_s, eff_s;
   logic [SPEED_W-1:0]        left_speed, right_speed;

   function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] v);
      logic [SPEED_W-1:0] r;
      if (v > SUM_W'(SPEED_MAX)) begin
         r = SPEED_W'(SPEED_MAX);
      end else if (v < SUM_W'(SPEED_MIN)) begin
         r = SPEED_W'(SPEED_MIN);
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

   assign word       = ucode_rom(step_ff);
   assign req_tready = word.latch;
   assign req_accept = req_tvalid && word.latch;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // input stage
   always_comb begin
      pos_c    = (req_tdata[POS_W-1:0] > POS_W'(POS_MAX)) ? POS_W'(POS_MAX)
                                                          : req_tdata[POS_W-1:0];
      err_wide = $signed(DIFF_W'(SETPOINT)) - $signed(DIFF_W'(pos_c));
      err_new  = err_wide[ERR_W-1:0];
   end

   // grade weight and grade value
   always_comb begin
      unique case (word.grade_sel)
         GRADE_SMALL:  weight = small_weight_ff;
         GRADE_MEDIUM: weight = medium_weight_ff;
         GRADE_LARGE:  weight = large_weight_ff;
         default:      weight = '0;
      endcase
      grade = full_ff ? (GRADE_W'(1) << GRADE_FRAC_BITS) : quo_ff;
   end

   // shared multiplier
   always_comb begin
      unique case (word.mul_sel)
         MUL_ERR_KP: begin
            opa = OPA_W'(err_ff);
            opb = $signed({1'b0, prop_gain_ff});
         end
         MUL_DIFF_KD: begin
            opa = OPA_W'(diff_ff);
            opb = $signed({1'b0, deriv_gain_ff});
         end
         MUL_GRADE: begin
            opa = $signed(OPA_W'(grade));
            opb = $signed({1'b0, weight});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      prod_in = PROD_W'(opa) * PROD_W'(opb);
   end

   // membership numerator and span reciprocal for the selected grade
   always_comb begin
      num       = '0;
      recip_sel = RECIP_SMALL;
      unique case (word.grade_sel)
         GRADE_SMALL: begin
            recip_sel = RECIP_SMALL;
            if (mag_ff < MAG_W'(SMALL_END)) begin
               num = SPAN_W'(MAG_W'(SMALL_END) - mag_ff);
            end
         end
         GRADE_MEDIUM: begin
            recip_sel = RECIP_MEDIUM;
            if (mag_ff > MAG_W'(MED_START) && mag_ff < MAG_W'(MED_PEAK)) begin
               num = SPAN_W'(mag_ff - MAG_W'(MED_START));
            end else if (mag_ff >= MAG_W'(MED_PEAK) && mag_ff < MAG_W'(MED_END)) begin
               num = SPAN_W'(MAG_W'(MED_END) - mag_ff);
            end
         end
         GRADE_LARGE: begin
            recip_sel = RECIP_LARGE;
            if (mag_ff > MAG_W'(LARGE_START) && mag_ff < MAG_W'(LARGE_END)) begin
               num = SPAN_W'(mag_ff - MAG_W'(LARGE_START));
            end
         end
         default: begin
            num = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      err_in   = err_ff;
      diff_in  = diff_ff;
      mag_in   = mag_ff;
      pd_in    = pd_ff;
      fz_in    = fz_ff;
      tot_in   = tot_ff;
      eff_in   = eff_ff;
      num_in   = num_ff;
      recip_in = recip_ff;
      quo_in   = quo_ff;
      full_in  = full_ff;

      if (req_accept) begin
         err_in  = err_new;
         diff_in = DIFF_W'(err_new) - DIFF_W'(prev_err_ff);
         mag_in  = err_new[ERR_W-1] ? MAG_W'(-err_new) : MAG_W'(err_new);
      end

      fz_signed  = $signed(TOT_W'(fz_ff));
      tot_biased = tot_ff + $signed(TRUNC_BIAS);

      unique case (word.acc_op)
         ACC_PD_LOAD: begin
            pd_in = PD_W'(prod_ff);
            fz_in = '0;
         end
         ACC_PD_ADD: begin
            pd_in = pd_ff + PD_W'(prod_ff);
         end
         ACC_FZ_ADD: begin
            fz_in = fz_ff + FZ_W'(prod_ff);
         end
         ACC_TOTAL: begin
            // fuzzy term keeps the sign of the error, positive when the error is zero
            tot_in = (TOT_W'(pd_ff) <<< GRADE_FRAC_BITS)
                   + (err_ff[ERR_W-1] ? -fz_signed : fz_signed);
         end
         ACC_EFFORT: begin
            // halve and drop fraction bits, truncating toward zero
            eff_in = tot_ff[TOT_W-1] ? EFF_W'(tot_biased >>> SHIFT)
                                     : EFF_W'(tot_ff >>> SHIFT);
         end
         default: begin
            pd_in = pd_ff;
         end
      endcase

      quo_prod = num_ff * recip_ff;
      unique case (word.div_op)
         DIV_INIT: begin
            num_in   = num;
            recip_in = recip_sel;
            full_in  = (word.grade_sel == GRADE_LARGE) && (mag_ff >= MAG_W'(LARGE_END));
         end
         DIV_STEP: begin
            // numerator over span as a scaled reciprocal product
            quo_in = GRADE_W'(quo_prod >> RECIP_SHIFT);
         end
         default: begin
            num_in = num_ff;
         end
      endcase
   end

   // speeds and output register
   always_comb begin
      base_s      = $signed(SUM_W'(base_speed_ff));
      eff_s       = SUM_W'(eff_ff);
      left_speed  = clamp_speed(base_s + eff_s);
      right_speed = clamp_speed(base_s - eff_s);

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (word.emit && out_free) begin
         rsp_data_in  = RSP_DATA_W'({right_speed, left_speed});
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      prev_err_in = req_accept ? err_new : prev_err_ff;
   end

   // sequencer
   always_comb begin
      unique case (word.cond)
         COND_NEXT:     step_in = step_ff + STEP_W'(1);
         COND_WAIT_REQ: step_in = req_accept ? step_ff + STEP_W'(1) : word.target;
         COND_WAIT_OUT: step_in = out_free ? word.target : step_ff;
         default:       step_in = step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         prev_err_ff      <= '0;
         prop_gain_ff     <= '0;
         deriv_gain_ff    <= '0;
         small_weight_ff  <= '0;
         medium_weight_ff <= '0;
         large_weight_ff  <= '0;
         base_speed_ff    <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_err_ff  <= prev_err_in;
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata;
               CSR_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata;
               CSR_SMALL_WEIGHT:  small_weight_ff  <= csr_wdata;
               CSR_MEDIUM_WEIGHT: medium_weight_ff <= csr_wdata;
               CSR_LARGE_WEIGHT:  large_weight_ff  <= csr_wdata;
               CSR_BASE_SPEED:    base_speed_ff    <= csr_wdata[BASE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      pd_ff       <= pd_in;
      fz_ff       <= fz_in;
      tot_ff      <= tot_in;
      eff_ff      <= eff_in;
      num_ff      <= num_in;
      recip_ff    <= recip_in;
      quo_ff      <= quo_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- dv/hybrid_fuzzy_pd_steering_tb.sv -----
module hybrid_fuzzy_pd_steering_tb;
   import hfpd_pkg::*;

   localparam int GAIN_FRAC  = GAIN_FRAC_BITS_DEF;
   localparam int GRADE_FRAC = GRADE_FRAC_BITS_DEF;
   localparam int GAIN_MAX   = 65535;
   localparam int BASE_MAX   = 255;
   localparam int POS_FIELD_MAX = 8191;
   // indexes past the register map, writes there must be dropped
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 3 * GRADE_FRAC + 30;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
   } speed_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [12:0] line_position
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [8:0] left_speed, [17:9] right_speed
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block's registers and error history
   int prop_gain = 0;
   int deriv_gain = 0;
   int small_weight = 0;
   int medium_weight = 0;
   int large_weight = 0;
   int base_speed = 0;
   int last_error = 0;

   speed_pair_type speeds_due[$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   hybrid_fuzzy_pd_steering i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint grade_of(input int num, input int span);
      return (longint'(num) << GRADE_FRAC) / span;
   endfunction

   function automatic logic signed [SPEED_W-1:0] saturate_speed(input longint v);
      longint c;
      c = v;
      if (c > SPEED_MAX) c = SPEED_MAX;
      if (c < SPEED_MIN) c = SPEED_MIN;
      return c[SPEED_W-1:0];
   endfunction

   // steering law for one position sample, advances the error history
   function automatic speed_pair_type predict_speeds(input logic [POS_W-1:0] position);
      int             pos;
      int             err;
      int             diff;
      int             mag;
      longint         pd;
      longint         g_small;
      longint         g_med;
      longint         g_large;
      longint         fuzzy;
      longint         total;
      longint         effort;
      speed_pair_type sp;
      pos = int'(position);
      if (pos > POS_MAX) pos = POS_MAX;
      err = SETPOINT - pos;
      diff = err - last_error;
      last_error = err;
      pd = longint'(err) * prop_gain + longint'(diff) * deriv_gain;
      mag = (err < 0) ? -err : err;
      g_small = 0;
      g_med = 0;
      g_large = 0;
      if (mag < SMALL_END) g_small = grade_of(SMALL_END - mag, SMALL_END);
      if (mag > MED_START && mag < MED_PEAK) begin
         g_med = grade_of(mag - MED_START, MED_PEAK - MED_START);
      end else if (mag >= MED_PEAK && mag < MED_END) begin
         g_med = grade_of(MED_END - mag, MED_END - MED_PEAK);
      end
      if (mag >= LARGE_END) begin
         g_large = longint'(1) << GRADE_FRAC;
      end else if (mag > LARGE_START) begin
         g_large = grade_of(mag - LARGE_START, LARGE_END - LARGE_START);
      end
      fuzzy = g_small * small_weight + g_med * medium_weight + g_large * large_weight;
      if (err < 0) fuzzy = -fuzzy;
      total = fuzzy + pd * (longint'(1) << GRADE_FRAC);
      // halve and drop the fraction in one step, toward zero
      effort = ((total < 0) ? -total : total) >> (GRADE_FRAC + GAIN_FRAC + 1);
      if (total < 0) effort = -effort;
      sp.left_speed = saturate_speed(longint'(base_speed) + effort);
      sp.right_speed = saturate_speed(longint'(base_speed) - effort);
      return sp;
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         speeds_due.push_back(predict_speeds(req_tdata[POS_W-1:0]));
      end
   end

   always @(posedge clock) begin : check_speeds
      speed_pair_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (speeds_due.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            due = speeds_due.pop_front();
            if (rsp_tdata[SPEED_W-1:0] !== due.left_speed) begin
               $error("left_speed: expected %0d, got %0d", due.left_speed,
                      $signed(rsp_tdata[SPEED_W-1:0]));
               mismatch_count++;
            end
            if (rsp_tdata[2*SPEED_W-1:SPEED_W] !== due.right_speed) begin
               $error("right_speed: expected %0d, got %0d", due.right_speed,
                      $signed(rsp_tdata[2*SPEED_W-1:SPEED_W]));
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_position(input logic [POS_W-1:0] pos);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(pos);
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // always advances the clock so valid is never dropped and raised together
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (speeds_due.size() != 0);
   endtask

   // leaves csr_we high, the caller lowers it after the last write
   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_PROP_GAIN:     prop_gain = int'(value);
         CSR_DERIV_GAIN:    deriv_gain = int'(value);
         CSR_SMALL_WEIGHT:  small_weight = int'(value);
         CSR_MEDIUM_WEIGHT: medium_weight = int'(value);
         CSR_LARGE_WEIGHT:  large_weight = int'(value);
         CSR_BASE_SPEED:    base_speed = int'(value[BASE_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic program_settings(input int kp, input int kd, input int ws, input int wm,
                                   input int wl, input int base);
      write_register(CSR_PROP_GAIN, CSR_DATA_W'(kp));
      write_register(CSR_DERIV_GAIN, CSR_DATA_W'(kd));
      write_register(CSR_SMALL_WEIGHT, CSR_DATA_W'(ws));
      write_register(CSR_MEDIUM_WEIGHT, CSR_DATA_W'(wm));
      write_register(CSR_LARGE_WEIGHT, CSR_DATA_W'(wl));
      write_register(CSR_BASE_SPEED, CSR_DATA_W'(base));
      csr_we <= 1'b0;
   endtask

   function automatic int pick_gain();
      case ($urandom_range(3))
         0: return 0;
         1: return GAIN_MAX;
         2: return $urandom_range(63);
         default: return $urandom_range(GAIN_MAX);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] previous);
      int pos;
      int knee;
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) begin
         // slow drift as the line wanders under the sensor bar
         pos = int'(previous);
         if (pos > POS_MAX) pos = POS_MAX;
         pos = pos + int'($urandom_range(300)) - 150;
         if (pos < 0) pos = 0;
         if (pos > POS_MAX) pos = POS_MAX;
      end else if (roll < 80) begin
         pos = $urandom_range(POS_FIELD_MAX);
      end else if (roll < 95) begin
         case ($urandom_range(6))
            0: knee = 0;
            1: knee = MED_START;
            2: knee = SMALL_END;
            3: knee = MED_PEAK;
            4: knee = LARGE_START;
            5: knee = MED_END;
            default: knee = LARGE_END;
         endcase
         knee = knee + int'($urandom_range(4)) - 2;
         if (knee < 0) knee = 0;
         if (knee > LARGE_END) knee = LARGE_END;
         pos = $urandom_range(1) ? SETPOINT + knee : SETPOINT - knee;
      end else begin
         pos = $urandom_range(POS_FIELD_MAX, POS_MAX + 1);
      end
      return POS_W'(pos);
   endfunction

   task automatic test_unconfigured();
      send_position(POS_W'(SETPOINT));
      send_position('0);
      send_position(POS_W'(POS_FIELD_MAX));
      wait_for_responses();
   endtask

   // errors at and either side of the grade curve knees, both signs; 3500 only from below
   task automatic test_membership_knees();
      int knee_errors[14] = '{499, -500, 501, -749, 750, -1124, 1125, -1126, 1499, -1500,
                              1501, -1749, 1750, -3499};
      program_settings(16, 8, 200, 300, 400, 128);
      foreach (knee_errors[k]) send_position(POS_W'(SETPOINT - knee_errors[k]));
      wait_for_responses();
   endtask

   task automatic test_speed_saturation();
      program_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, BASE_MAX);
      send_position('0);
      send_position(POS_W'(POS_MAX));
      send_position(POS_W'(POS_MAX + 1));
      send_position(POS_W'(SETPOINT));
      wait_for_responses();
   endtask

   task automatic test_unknown_register();
      write_register(CSR_SPARE_LO, CSR_DATA_W'($urandom_range(GAIN_MAX)));
      write_register(CSR_SPARE_HI, CSR_DATA_W'($urandom_range(GAIN_MAX)));
      csr_we <= 1'b0;
      send_position(POS_W'(1000));
      send_position(POS_W'(6200));
      wait_for_responses();
   endtask

   task automatic test_random_steering(input int sender_pct, input int receiver_pct,
                                       input int per_setting);
      logic [POS_W-1:0] pos;
      pos = POS_W'(SETPOINT);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int s = 0; s < 4; s++) begin
         wait_for_responses();
         case (s)
            0: program_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, BASE_MAX);
            1: program_settings(0, 0, 0, 0, 0, $urandom_range(BASE_MAX));
            default: program_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                      pick_gain(), $urandom_range(BASE_MAX));
         endcase
         for (int n = 0; n < per_setting; n++) begin
            // hold off now and then until the pipeline has emptied
            if ($urandom_range(199) == 0) wait_for_responses();
            pos = pick_position(pos);
            send_position(pos);
         end
      end
      wait_for_responses();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 81;
      test_unconfigured();
      test_membership_knees();
      test_speed_saturation();
      test_unknown_register();
      test_random_steering(33, 81, 160);
      test_random_steering(81, 33, 160);
      test_random_steering(0, 0, 160);
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (speeds_due.size() != 0) begin
         $error("%0d responses never arrived", speeds_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
